FILE: rtl/core/ebml_element_header_parser_unit_macros.svh
// Assertion macros used by the header checker file
`ifndef EBML_ELEMENT_HEADER_PARSER_UNIT_MACROS_SVH
`define EBML_ELEMENT_HEADER_PARSER_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define EHP_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define EHP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/core/ebml_hdr_pkg.sv
// Package: parse phases, status codes, register indices, field widths and byte decode helpers
package ebml_hdr_pkg;

    localparam int unsigned POS_W   = 64;
    localparam int unsigned START_W = 63;
    localparam int unsigned ID_W    = 32;
    localparam int unsigned SIZE_W  = 64;
    localparam int unsigned OUT_W   = 176;
    localparam int unsigned CFG_W   = 64;

    typedef enum logic [2:0] {
        PH_ID_FIRST,
        PH_ID_REST,
        PH_SIZE_FIRST,
        PH_SIZE_REST,
        PH_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ENDS_LATE = 3'd1,
        ST_ID_ZERO   = 3'd2,
        ST_ID_LONG   = 3'd3,
        ST_ID_PAST   = 3'd4,
        ST_SIZE_PAST = 3'd5,
        ST_DEPTH     = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        REG_SCOPE_LEN = 3'd0,
        REG_MCOUNT    = 3'd1,
        REG_MID_A     = 3'd2,
        REG_MID_B     = 3'd3,
        REG_MID_C     = 3'd4,
        REG_MID_D     = 3'd5,
        REG_MID_E     = 3'd6,
        REG_MID_F     = 3'd7
    } cfg_reg_t;

    // Length of a vint from its first byte: 1..8, or 9 when the byte is zero
    function automatic logic [3:0] lead_len(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd9;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                n = 4'(8 - i);
            end
        end
        return n;
    endfunction

    // Value bits below the length marker of a first byte
    function automatic logic [6:0] lead_value(input logic [7:0] b, input logic [3:0] len);
        logic [7:0] m;
        m = (len > 4'd8) ? 8'h00 : ((8'h80 >> (len - 4'd1)) - 8'h01);
        return 7'(b & m);
    endfunction

    // All-ones size value for a size of len bytes, zero when len is 9
    function automatic logic [63:0] unknown_value(input logic [3:0] len);
        logic [63:0] v;
        v = '0;
        for (int i = 1; i <= 8; i++)
        begin
            if (len == 4'(i))
            begin
                v = (64'd1 << (7 * i)) - 64'd1;
            end
        end
        return v;
    endfunction

endpackage

FILE: rtl/core/ebml_element_header_parser_unit.sv
// Top level: EBML element header parser, one stream byte per cycle unless the output stalls
// Usage:
//   s_axis carries one stream byte per word in tdata[7:0]. Every accepted byte
//   advances the stream offset by one; offsets count from zero after reset.
//   m_axis carries one word per finished element header or header error.
//   A byte is decoded in the cycle it is accepted; its result sits in the
//   output register in the following cycle. One byte is taken every cycle
//   while no result stalls (throughput 1 byte/cycle), a rate set by the
//   single update of the parse state registers and scope end stack per byte.
//   When the receiver stalls with a result pending, s_axis_tready drops until
//   the output register is taken; the input side never waits otherwise.
//   cfg writes registers by index (0 scope length, 1 master count,
//   2..7 master ids); write only while no byte is in flight.
//   Reset clears the offset, the parse phase and the nesting depth, drops any
//   pending result and loads the default scope length; scope stack entries
//   are written on entry to a master element before they are ever read.
module ebml_element_header_parser_unit #(
    parameter int unsigned MAX_DEPTH = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [62:0] element_start, [94:63] element_id, [158:95] element_size,
    // [162:159] header_length, [166:163] nesting_level, [167] master_flag,
    // [168] unknown_size, [171:169] status, [175:172] zero
    output logic [ebml_hdr_pkg::OUT_W-1:0]    m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [ebml_hdr_pkg::CFG_W-1:0]    cfg_data
);
    import ebml_hdr_pkg::*;

    localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
    localparam int unsigned SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // configuration
    logic [62:0]   scope_len_reg;
    logic [2:0]    mcount_reg;
    logic [31:0]   mid_reg [6];

    // parse state
    logic [63:0]   pos_reg;
    phase_t        phase_reg, phase_next;
    logic [31:0]   id_acc_reg, id_acc_next;
    logic [2:0]    id_cnt_reg, id_cnt_next;
    logic [2:0]    id_len_reg, id_len_next;
    logic [63:0]   size_acc_reg, size_acc_next;
    logic [3:0]    size_cnt_reg, size_cnt_next;
    logic [3:0]    size_len_reg, size_len_next;
    logic [63:0]   hstart_reg, hstart_next;
    logic [63:0]   skip_reg, skip_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [63:0]   stack_reg [MAX_DEPTH];
    logic          push;
    logic [63:0]   push_val;

    // result register
    logic          out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic          emit;
    logic [OUT_W-1:0] res_data;

    logic          accept;
    logic [63:0]   p, nxt;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;
    assign p             = pos_reg;
    assign nxt           = (p == '1) ? p : p + 64'd1;

    always_comb
    begin
        logic [7:0]    b;
        phase_t        ph;
        logic [DW-1:0] nd;
        logic [63:0]   end_v;
        logic [3:0]    len;
        logic          fin_id, fin_size, err, mf;
        status_t       st;
        logic [31:0]   id_v, rid;
        logic [63:0]   sz, rsz, room, cend;
        logic [3:0]    slen, hl;
        logic [2:0]    mn;
        logic          unk;

        b = s_axis_tdata;
        phase_next    = phase_reg;
        id_acc_next   = id_acc_reg;
        id_cnt_next   = id_cnt_reg;
        id_len_next   = id_len_reg;
        size_acc_next = size_acc_reg;
        size_cnt_next = size_cnt_reg;
        size_len_next = size_len_reg;
        hstart_next   = hstart_reg;
        skip_next     = skip_reg;
        depth_next    = depth_reg;
        push     = 1'b0;
        push_val = '0;
        emit     = 1'b0;
        fin_id   = 1'b0;
        fin_size = 1'b0;
        err      = 1'b0;
        st       = ST_OK;
        rid      = '0;
        rsz      = '0;
        hl       = '0;
        mf       = 1'b0;
        unk      = 1'b0;
        id_v     = id_acc_reg;
        sz       = size_acc_reg;
        slen     = size_len_reg;
        len      = lead_len(b);

        ph = phase_reg;
        if (ph == PH_SKIP && p >= skip_reg)
        begin
            ph = PH_ID_FIRST;
        end
        phase_next = ph;

        // leave every scope whose end is reached; ends shrink inward
        nd = depth_reg;
        if (ph == PH_ID_FIRST)
        begin
            nd = '0;
            for (int i = 0; i < MAX_DEPTH; i++)
            begin
                if (DW'(i) < depth_reg && p < stack_reg[i])
                begin
                    nd = DW'(i + 1);
                end
            end
        end
        depth_next = nd;
        end_v = (nd == '0) ? {1'b0, scope_len_reg} : stack_reg[SW'(nd - DW'(1))];

        if (ph == PH_ID_FIRST && nd == '0 && p >= {1'b0, scope_len_reg})
        begin
            // outside the top-level scope: consume silently
        end
        else
        begin
            case (ph)
                PH_ID_FIRST:
                begin
                    hstart_next = p;
                    if (len == 4'd9)
                    begin
                        err = 1'b1;
                        st  = ST_ID_ZERO;
                    end
                    else if (len > 4'd4)
                    begin
                        err = 1'b1;
                        st  = ST_ID_LONG;
                    end
                    else if ({1'b0, p} + 65'(len) > {1'b0, end_v})
                    begin
                        err = 1'b1;
                        st  = ST_ID_PAST;
                    end
                    else
                    begin
                        id_v        = {24'd0, b};
                        id_acc_next = id_v;
                        id_cnt_next = 3'd1;
                        id_len_next = 3'(len);
                        if (len == 4'd1)
                        begin
                            fin_id = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_ID_REST;
                        end
                    end
                end
                PH_ID_REST:
                begin
                    id_v        = {id_acc_reg[23:0], b};
                    id_acc_next = id_v;
                    id_cnt_next = id_cnt_reg + 3'd1;
                    if (id_cnt_next >= id_len_reg)
                    begin
                        fin_id = 1'b1;
                    end
                end
                PH_SIZE_FIRST:
                begin
                    if ({1'b0, p} + 65'(len) > {1'b0, end_v})
                    begin
                        err = 1'b1;
                        st  = ST_SIZE_PAST;
                        rid = id_acc_reg;
                    end
                    else
                    begin
                        sz            = {57'd0, lead_value(b, len)};
                        slen          = len;
                        size_acc_next = sz;
                        size_cnt_next = 4'd1;
                        size_len_next = len;
                        if (len == 4'd1)
                        begin
                            fin_size = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_SIZE_REST;
                        end
                    end
                end
                PH_SIZE_REST:
                begin
                    sz            = {size_acc_reg[55:0], b};
                    size_acc_next = sz;
                    size_cnt_next = size_cnt_reg + 4'd1;
                    if (size_cnt_next >= size_len_reg)
                    begin
                        fin_size = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (fin_id && nxt >= end_v)
        begin
            err = 1'b1;
            st  = ST_SIZE_PAST;
            rid = id_v;
        end
        else if (fin_id)
        begin
            phase_next = PH_SIZE_FIRST;
        end

        mn = (mcount_reg > 3'd6) ? 3'd6 : mcount_reg;
        for (int i = 0; i < 6; i++)
        begin
            if (3'(i) < mn && mid_reg[i] == id_acc_reg)
            begin
                mf = 1'b1;
            end
        end
        room = end_v - nxt;
        cend = nxt + sz;

        if (err)
        begin
            emit       = 1'b1;
            mf         = 1'b0;
            skip_next  = end_v;
            phase_next = PH_SKIP;
        end
        else if (fin_size)
        begin
            emit = 1'b1;
            rid  = id_acc_reg;
            rsz  = sz;
            hl   = 4'(id_len_reg) + slen;
            unk  = (slen <= 4'd8) && (sz == unknown_value(slen));
            phase_next = PH_SKIP;
            if (sz > room)
            begin
                st        = ST_ENDS_LATE;
                skip_next = end_v;
            end
            else if (mf && nd >= DW'(MAX_DEPTH))
            begin
                st        = ST_DEPTH;
                skip_next = cend;
            end
            else if (mf)
            begin
                push       = 1'b1;
                push_val   = cend;
                depth_next = nd + DW'(1);
                phase_next = PH_ID_FIRST;
            end
            else
            begin
                skip_next = cend;
            end
        end
        else
        begin
            mf = 1'b0;
        end

        res_data = {4'd0, st, unk, mf, 4'(nd), hl, rsz, rid, hstart_next[62:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scope_len_reg <= '1;
            mcount_reg    <= '0;
            for (int i = 0; i < 6; i++)
            begin
                mid_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SCOPE_LEN: scope_len_reg <= cfg_data[62:0];
                REG_MCOUNT:    mcount_reg    <= cfg_data[2:0];
                REG_MID_A:     mid_reg[0]    <= cfg_data[31:0];
                REG_MID_B:     mid_reg[1]    <= cfg_data[31:0];
                REG_MID_C:     mid_reg[2]    <= cfg_data[31:0];
                REG_MID_D:     mid_reg[3]    <= cfg_data[31:0];
                REG_MID_E:     mid_reg[4]    <= cfg_data[31:0];
                REG_MID_F:     mid_reg[5]    <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            phase_reg    <= PH_ID_FIRST;
            id_acc_reg   <= '0;
            id_cnt_reg   <= '0;
            id_len_reg   <= '0;
            size_acc_reg <= '0;
            size_cnt_reg <= '0;
            size_len_reg <= '0;
            hstart_reg   <= '0;
            skip_reg     <= '0;
            depth_reg    <= '0;
        end
        else if (accept)
        begin
            pos_reg      <= nxt;
            phase_reg    <= phase_next;
            id_acc_reg   <= id_acc_next;
            id_cnt_reg   <= id_cnt_next;
            id_len_reg   <= id_len_next;
            size_acc_reg <= size_acc_next;
            size_cnt_reg <= size_cnt_next;
            size_len_reg <= size_len_next;
            hstart_reg   <= hstart_next;
            skip_reg     <= skip_next;
            depth_reg    <= depth_next;
        end
    end

    // scope end stack: written on entry, read only below the depth
    always_ff @(posedge clk)
    begin
        if (accept && push)
        begin
            stack_reg[SW'(depth_next - DW'(1))] <= push_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg <= res_data;
        end
    end

endmodule

FILE: rtl/core/ebml_hdr_checker.sv
// Port checker for the EBML header parser, bound to the top level
`include "ebml_element_header_parser_unit_macros.svh"

module ebml_hdr_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [ebml_hdr_pkg::OUT_W-1:0] m_axis_tdata
);
    import ebml_hdr_pkg::*;

    logic [2:0] status;
    logic [3:0] hlen;

    assign status = m_axis_tdata[171:169];
    assign hlen   = m_axis_tdata[162:159];

    // an empty output register always takes a byte
    `EHP_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !m_axis_tvalid, s_axis_tready,
        "ready low with empty output")
    // a stalled word holds
    `EHP_ASSERT_NEXT(a_hold_stalled, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled word changed")
    // good headers carry a length, ones that fail to parse none
    `EHP_ASSERT_IMP(a_ok_has_length, clk, rst_n, m_axis_tvalid && status == ST_OK,
        hlen != 4'd0, "ok header with zero length")
    `EHP_ASSERT_IMP(a_err_no_length, clk, rst_n,
        m_axis_tvalid && status >= ST_ID_ZERO && status <= ST_SIZE_PAST,
        hlen == 4'd0, "failed header with length")
endmodule

bind ebml_element_header_parser_unit ebml_hdr_checker u_ebml_hdr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/tb_top.sv
// Testbench for the EBML element header parser: byte streams, scope and depth cases
module tb_top;
    import ebml_hdr_pkg::*;

    localparam int  DEPTH_MAX   = 8;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  ITEM_TARGET = 1150;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        logic [62:0] start;
        logic [31:0] id;
        logic [63:0] size;
        logic [3:0]  hlen;
        logic [3:0]  level;
        logic        mflag;
        logic        unk;
        logic [2:0]  status;
    } hdr_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;

    ebml_element_header_parser_unit #(.MAX_DEPTH(DEPTH_MAX)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Parser mirror: configuration
    logic [63:0] scope_len = 64'h7FFF_FFFF_FFFF_FFFF;
    logic [2:0]  mcount = '0;
    logic [31:0] mids[6] = '{default: '0};

    // Parser mirror: state
    logic [63:0] pos = '0;
    phase_t      ph = PH_ID_FIRST;
    logic [31:0] id_acc = '0;
    int          id_cnt = 0;
    int          id_len = 0;
    logic [63:0] sz_acc = '0;
    int          sz_cnt = 0;
    int          sz_len = 0;
    logic [63:0] hstart = '0;
    logic [63:0] skip_tgt = '0;
    logic [63:0] scope_ends[DEPTH_MAX] = '{default: '0};
    int          depth = 0;
    hdr_res_t    new_res;

    hdr_res_t    headers_pending[$];
    int          errors = 0;
    int          checked = 0;
    int          bytes_sent = 0;
    int          phases = 0;
    int          cycles = 0;
    int          stall_left = 0;
    bit          idle_on = 1'b0;

    function automatic int vint_len(input logic [7:0] b);
        int n;
        n = 1;
        for (int m = 7; m >= 0; m--)
        begin
            if (b[m])
            begin
                return n;
            end
            n++;
        end
        return 9;
    endfunction

    function automatic bit is_master_id(input logic [31:0] id);
        int n;
        n = (mcount > 3'd6) ? 6 : int'(mcount);
        for (int i = 0; i < n; i++)
        begin
            if (mids[i] == id)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void emit(input logic [31:0] id, input logic [63:0] size,
                                 input int hl, input logic mf, input logic unk,
                                 input status_t st);
        new_res.start  = hstart[62:0];
        new_res.id     = id;
        new_res.size   = size;
        new_res.hlen   = 4'(hl);
        new_res.level  = 4'(depth);
        new_res.mflag  = mf;
        new_res.unk    = unk;
        new_res.status = st;
    endfunction

    function automatic bit header_fail(input logic [31:0] id, input status_t st,
                                       input logic [63:0] e);
        emit(id, '0, 0, 1'b0, 1'b0, st);
        skip_tgt = e;
        ph = PH_SKIP;
        return 1'b1;
    endfunction

    function automatic bit close_id(input logic [63:0] nxt, input logic [63:0] e);
        if (nxt >= e)
        begin
            return header_fail(id_acc, ST_SIZE_PAST, e);
        end
        ph = PH_SIZE_FIRST;
        return 1'b0;
    endfunction

    function automatic bit close_size(input logic [63:0] nxt, input logic [63:0] e);
        logic        mf;
        logic        unk;
        logic [63:0] room;
        logic [63:0] cend;
        int          hl;
        mf   = is_master_id(id_acc);
        unk  = (sz_len >= 1 && sz_len <= 8 &&
                sz_acc == ((64'd1 << (7 * sz_len)) - 64'd1));
        room = e - nxt;
        hl   = id_len + sz_len;
        if (sz_acc > room)
        begin
            emit(id_acc, sz_acc, hl, mf, unk, ST_ENDS_LATE);
            skip_tgt = e;
            ph = PH_SKIP;
            return 1'b1;
        end
        cend = nxt + sz_acc;
        if (mf && depth >= DEPTH_MAX)
        begin
            emit(id_acc, sz_acc, hl, mf, unk, ST_DEPTH);
            skip_tgt = cend;
            ph = PH_SKIP;
            return 1'b1;
        end
        emit(id_acc, sz_acc, hl, mf, unk, ST_OK);
        if (mf)
        begin
            scope_ends[depth] = cend;
            depth++;
            ph = PH_ID_FIRST;
        end
        else
        begin
            skip_tgt = cend;
            ph = PH_SKIP;
        end
        return 1'b1;
    endfunction

    // Advance the parser mirror by one byte; returns 1 when a header word is due
    function automatic bit parse_byte(input logic [7:0] b);
        logic [63:0] p;
        logic [63:0] nxt;
        logic [63:0] e;
        int          len;
        p   = pos;
        nxt = (p == '1) ? p : p + 64'd1;
        pos = nxt;
        if (ph == PH_SKIP && p >= skip_tgt)
        begin
            ph = PH_ID_FIRST;
        end
        if (ph == PH_ID_FIRST)
        begin
            while (depth > 0 && depth <= DEPTH_MAX && p >= scope_ends[depth-1])
            begin
                depth--;
            end
            if (depth == 0 && p >= scope_len)
            begin
                return 1'b0;
            end
        end
        e = (depth == 0 || depth > DEPTH_MAX) ? scope_len : scope_ends[depth-1];
        len = vint_len(b);
        case (ph)
            PH_ID_FIRST:
            begin
                hstart = p;
                if (len == 9)
                begin
                    return header_fail('0, ST_ID_ZERO, e);
                end
                if (len > 4)
                begin
                    return header_fail('0, ST_ID_LONG, e);
                end
                if (p + 64'(len) > e)
                begin
                    return header_fail('0, ST_ID_PAST, e);
                end
                id_acc = {24'd0, b};
                id_cnt = 1;
                id_len = len;
                if (len == 1)
                begin
                    return close_id(nxt, e);
                end
                ph = PH_ID_REST;
            end
            PH_ID_REST:
            begin
                id_acc = {id_acc[23:0], b};
                id_cnt++;
                if (id_cnt >= id_len)
                begin
                    return close_id(nxt, e);
                end
            end
            PH_SIZE_FIRST:
            begin
                if (p + 64'(len) > e)
                begin
                    return header_fail(id_acc, ST_SIZE_PAST, e);
                end
                sz_acc = (len == 9) ? '0 : 64'(b & ((8'h80 >> (len - 1)) - 8'h01));
                sz_cnt = 1;
                sz_len = len;
                if (len == 1)
                begin
                    return close_size(nxt, e);
                end
                ph = PH_SIZE_REST;
            end
            PH_SIZE_REST:
            begin
                sz_acc = {sz_acc[55:0], b};
                sz_cnt++;
                if (sz_cnt >= sz_len)
                begin
                    return close_size(nxt, e);
                end
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    task automatic report(input string field, input logic [63:0] got,
                          input logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h expected 0x%0h (cycle %0d)",
                 field, got, want, cycles);
        errors++;
    endtask

    // Receiver: random stall bursts while idling is on
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 6) == 0)
        begin
            stall_left = $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Check outgoing words first, then advance the mirror on an accepted byte
    always @(posedge clk)
    begin
        hdr_res_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (headers_pending.size() == 0)
                begin
                    report("unexpected word start", 64'(m_axis_tdata[62:0]), 64'd0);
                end
                else
                begin
                    want = headers_pending.pop_front();
                    checked++;
                    if (m_axis_tdata[62:0] !== want.start)
                        report("element_start", 64'(m_axis_tdata[62:0]), 64'(want.start));
                    if (m_axis_tdata[94:63] !== want.id)
                        report("element_id", 64'(m_axis_tdata[94:63]), 64'(want.id));
                    if (m_axis_tdata[158:95] !== want.size)
                        report("element_size", m_axis_tdata[158:95], want.size);
                    if (m_axis_tdata[162:159] !== want.hlen)
                        report("header_length", 64'(m_axis_tdata[162:159]), 64'(want.hlen));
                    if (m_axis_tdata[166:163] !== want.level)
                        report("nesting_level", 64'(m_axis_tdata[166:163]), 64'(want.level));
                    if (m_axis_tdata[167] !== want.mflag)
                        report("master_flag", 64'(m_axis_tdata[167]), 64'(want.mflag));
                    if (m_axis_tdata[168] !== want.unk)
                        report("unknown_size", 64'(m_axis_tdata[168]), 64'(want.unk));
                    if (m_axis_tdata[171:169] !== want.status)
                        report("status", 64'(m_axis_tdata[171:169]), 64'(want.status));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (parse_byte(s_axis_tdata))
                begin
                    headers_pending.push_back(new_res);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            REG_SCOPE_LEN: scope_len = {1'b0, val[62:0]};
            REG_MCOUNT:    mcount = val[2:0];
            default:       mids[int'(idx) - 2] = val[31:0];
        endcase
        // let cfg_valid drop between writes
        @(posedge clk);
    endtask

    // Hold until every header word is out, then let the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (headers_pending.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Set the scope relative to the current offset, send, pad out to the scope end
    task automatic run_stream(input byte_q_t q, input int scope_rel);
        write_reg(REG_SCOPE_LEN, pos + 64'(scope_rel));
        foreach (q[i])
        begin
            send_byte(q[i]);
        end
        while (pos < scope_len)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
        drain();
        phases++;
    endtask

    function automatic void put_id(input logic [31:0] id, ref byte_q_t q);
        bit lead;
        lead = 1'b0;
        for (int i = 3; i >= 0; i--)
        begin
            if (id[8*i +: 8] != 8'd0 || lead || i == 0)
            begin
                lead = 1'b1;
                q.push_back(id[8*i +: 8]);
            end
        end
    endfunction

    function automatic logic [31:0] random_id();
        int          len;
        logic [31:0] id;
        len = $urandom_range(1, 4);
        id  = $urandom;
        id  = id & ((32'd1 << (8 * len - len)) - 32'd1);
        return id | (32'd1 << (8 * len - len));
    endfunction

    function automatic void put_size(input logic [63:0] sz, input int len, ref byte_q_t q);
        if (len == 9)
        begin
            q.push_back(8'h00);
            for (int i = 7; i >= 0; i--)
                q.push_back(sz[8*i +: 8]);
        end
        else
        begin
            q.push_back((8'h80 >> (len - 1)) | 8'(sz >> (8 * (len - 1))));
            for (int i = len - 2; i >= 0; i--)
                q.push_back(sz[8*i +: 8]);
        end
    endfunction

    // Build one element; chain forces a single nested master per level
    task automatic build_elem(input int lvl, input int chain, input bit tidy,
                              ref byte_q_t q);
        byte_q_t     body;
        logic [31:0] id;
        logic [63:0] sz;
        int          len;
        int          nm;
        bit          mst;
        nm  = (mcount > 3'd6) ? 6 : int'(mcount);
        mst = (chain > 0) || (nm > 0 && lvl < 10 && $urandom_range(0, 2) == 0);
        if (!tidy && $urandom_range(0, 19) == 0)
        begin
            repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        id = (chain > 0) ? mids[2] : (mst ? mids[$urandom_range(0, nm - 1)] : random_id());
        if (mst)
        begin
            if (chain > 0)
                build_elem(lvl + 1, chain - 1, tidy, body);
            else if (lvl < 4)
                repeat ($urandom_range(0, 3)) build_elem(lvl + 1, 0, tidy, body);
        end
        else
        begin
            repeat ($urandom_range(0, 5)) body.push_back(8'($urandom_range(0, 255)));
        end
        sz = body.size();
        len = 1;
        while (len < 9 && sz >= (64'd1 << (7 * len)) - 64'd1)
            len++;
        if ($urandom_range(0, 2) == 0)
            len = $urandom_range(len, 9);
        if (!tidy && $urandom_range(0, 15) == 0)
        begin
            len = $urandom_range(1, 8);
            sz  = (64'd1 << (7 * len)) - 64'd1;
        end
        else if (!tidy && $urandom_range(0, 15) == 0)
        begin
            sz = sz + 64'($urandom_range(1, 3));
        end
        put_id(id, q);
        put_size(sz, len, q);
        foreach (body[i])
            q.push_back(body[i]);
    endtask

    task automatic setup_masters();
        write_reg(REG_MCOUNT, 64'd6);
        write_reg(REG_MID_A, 64'h1A45_DFA3);
        write_reg(REG_MID_B, 64'h1853_8067);
        write_reg(REG_MID_C, 64'h0000_00AE);
        write_reg(REG_MID_D, 64'h0000_4286);
        write_reg(REG_MID_E, 64'h002A_D7B1);
        write_reg(REG_MID_F, 64'hFFFF_FFFF);
    endtask

    task automatic test_header_forms();
        byte_q_t q;
        setup_masters();
        // plain element, master holding a zero id byte, 9-byte size, id too long
        q = '{8'hEC, 8'h81, 8'hAA,
              8'hAE, 8'h83, 8'h00, 8'h11, 8'h22,
              8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h5A,
              8'h10, 8'hFF, 8'hFF, 8'hFF, 8'h81, 8'h00,
              8'h08};
        run_stream(q, q.size() + 2);
        // unknown size runs past the scope
        q = '{8'h42, 8'h86, 8'hFF, 8'h01};
        run_stream(q, q.size());
    endtask

    task automatic test_scope_edges();
        byte_q_t q;
        // id ends right at the scope end
        q = '{8'h40, 8'h01};
        run_stream(q, 2);
        // id crosses the scope end
        q = '{8'h10, 8'h01};
        run_stream(q, 3);
        // size field crosses the scope end
        q = '{8'h81, 8'h20};
        run_stream(q, 3);
        // empty scope: everything is consumed silently
        q = '{8'h81, 8'h80, 8'hFF};
        run_stream(q, 0);
        // largest scope with a well-formed stream only
        write_reg(REG_SCOPE_LEN, 64'h7FFF_FFFF_FFFF_FFFF);
        q = '{};
        repeat (3) build_elem(0, 0, 1'b1, q);
        foreach (q[i])
            send_byte(q[i]);
        drain();
        phases++;
    endtask

    task automatic test_depth_limit();
        byte_q_t q;
        q = '{};
        build_elem(0, DEPTH_MAX + 1, 1'b1, q);
        run_stream(q, q.size());
        write_reg(REG_MCOUNT, 64'd0);
        write_reg(REG_MID_A, 64'd0);
    endtask

    task automatic test_random_streams();
        byte_q_t q;
        int      rel;
        while (bytes_sent < ITEM_TARGET)
        begin
            idle_on = (bytes_sent < ITEM_TARGET - 200) && ($urandom_range(0, 3) != 0);
            write_reg(REG_MCOUNT, 64'($urandom_range(0, 7)));
            for (int r = 2; r <= 7; r++)
            begin
                if ($urandom_range(0, 1) == 0)
                    write_reg(cfg_reg_t'(r), 64'(random_id()));
            end
            q = '{};
            repeat ($urandom_range(1, 6)) build_elem(0, 0, 1'b0, q);
            rel = q.size();
            if ($urandom_range(0, 3) == 0)
                rel = rel + $urandom_range(0, 6) - 3;
            run_stream(q, (rel < 0) ? 0 : rel);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;
        test_header_forms();
        test_scope_edges();
        test_depth_limit();
        test_random_streams();
        drain();
        $display("Sent %0d stream bytes in %0d scopes, checked %0d header words",
                 bytes_sent, phases, checked);
        $display("Covered all header errors, depth limit, unknown sizes, scope extremes");
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ebml_hdr_pkg.sv
rtl/core/ebml_element_header_parser_unit.sv
rtl/core/ebml_hdr_checker.sv
tb/tb_top.sv
